// ===== hdl/ipt_pkg.sv =====
`default_nettype none

package ipt_pkg;

   localparam int ID_CAPACITY = 1024;
   localparam int ID_W        = $clog2(ID_CAPACITY);
   localparam int CNT_W       = ID_W + 1;
   localparam int VALUE_W     = 32;
   localparam int PRI_W       = 16;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;

   localparam logic [PRI_W-1:0] PRI_MAX      = '1;
   localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(ID_CAPACITY);

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 3'd0,
      OP_PROMOTE  = 3'd1,
      OP_GET_MAX  = 3'd2,
      OP_POP_MAX  = 3'd3,
      OP_IS_VALID = 3'd4,
      OP_GET      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_BAD_ID    = 2'd2,
      STATUS_NO_IDS    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_APPLY,
      ST_SCAN,
      ST_FETCH,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/indexed_priority_table_unit.sv =====
`default_nettype none

// add, promote, is valid, get and unused ops: lookup reads the table, apply forms the result
//   and the result strobe is registered
// get max / pop max: scan every id handed out so far, then fetch and finish (empty answer
//   straight from scan); one stored entry read per cycle through one shared priority compare
// one transaction at a time: busy stays high until the result strobe; the receiver cannot stall
// synchronous reset clears the id counter and the control state; no clearing pass is needed

module indexed_priority_table_unit
   import ipt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [ID_W-1:0]     req_entry_id,
   input  wire logic [VALUE_W-1:0]  req_value_in,
   output      logic                rsp_valid,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [ID_W-1:0]     rsp_new_id,
   output      logic [VALUE_W-1:0]  rsp_value_out,
   output      logic [PRI_W-1:0]    rsp_priority_out,
   output      logic                rsp_is_live
);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     next_id_ff, next_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [OP_W-1:0]      op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [CNT_W-1:0]     scan_addr_ff, scan_addr_in;
   logic [ID_W-1:0]      scan_tag_ff, scan_tag_in;
   logic                 pend_ff, pend_in;
   logic                 found_ff, found_in;
   logic [PRI_W-1:0]     best_pri_ff, best_pri_in;
   logic [ID_W-1:0]      best_id_ff, best_id_in;

   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_new_id_ff, rsp_new_id_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [PRI_W-1:0]     rsp_pri_ff, rsp_pri_in;
   logic                 rsp_live_ff, rsp_live_in;

   // memories
   logic [VALUE_W-1:0]   val_mem  [ID_CAPACITY];
   logic [PRI_W-1:0]     pri_mem  [ID_CAPACITY];
   logic                 live_mem [ID_CAPACITY];
   logic [VALUE_W-1:0]   val_rd_ff;
   logic [PRI_W-1:0]     pri_rd_ff;
   logic                 live_rd_ff;

   logic [ID_W-1:0]      rd_addr;
   logic                 val_we, pri_we, live_we;
   logic [ID_W-1:0]      val_waddr, pri_waddr, live_waddr;
   logic [VALUE_W-1:0]   val_wdata;
   logic [PRI_W-1:0]     pri_wdata;
   logic                 live_wdata;

   logic                 scan_issue, scan_done, id_live, is_scan_op;

   // entries at or above next_id were never handed out, so their live bits are ignored
   assign id_live    = ({1'b0, id_ff} < next_id_ff) && live_rd_ff;
   assign scan_issue = scan_addr_ff < next_id_ff;
   assign scan_done  = !scan_issue && !pend_ff;
   assign is_scan_op = (req_op == OP_GET_MAX) || (req_op == OP_POP_MAX);

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      val_rd_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pri_we) begin
         pri_mem[pri_waddr] <= pri_wdata;
      end
      pri_rd_ff <= pri_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[live_waddr] <= live_wdata;
      end
      live_rd_ff <= live_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      value_ff      <= value_in;
      scan_addr_ff  <= scan_addr_in;
      scan_tag_ff   <= scan_tag_in;
      pend_ff       <= pend_in;
      found_ff      <= found_in;
      best_pri_ff   <= best_pri_in;
      best_id_ff    <= best_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_new_id_ff <= rsp_new_id_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_live_ff   <= rsp_live_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = is_scan_op ? ST_SCAN : ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_IDLE;
         ST_SCAN: begin
            if (scan_done) begin
               state_in = found_ff ? ST_FETCH : ST_IDLE;
            end
         end
         ST_FETCH:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      next_id_in    = next_id_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      value_in      = value_ff;
      scan_addr_in  = scan_addr_ff;
      scan_tag_in   = scan_tag_ff;
      pend_in       = 1'b0;
      found_in      = found_ff;
      best_pri_in   = best_pri_ff;
      best_id_in    = best_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_new_id_in = rsp_new_id_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_live_in   = rsp_live_ff;
      rd_addr       = id_ff;
      val_we        = 1'b0;
      pri_we        = 1'b0;
      live_we       = 1'b0;
      val_waddr     = next_id_ff[ID_W-1:0];
      pri_waddr     = next_id_ff[ID_W-1:0];
      live_waddr    = next_id_ff[ID_W-1:0];
      val_wdata     = value_ff;
      pri_wdata     = '0;
      live_wdata    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in        = req_op;
               id_in        = req_entry_id;
               value_in     = req_value_in;
               scan_addr_in = '0;
               found_in     = 1'b0;
            end
         end
         ST_LOOKUP: begin
            rd_addr = id_ff;
         end
         ST_APPLY: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_new_id_in = '0;
            rsp_value_in  = '0;
            rsp_pri_in    = '0;
            rsp_live_in   = 1'b0;
            unique case (op_ff)
               OP_ADD: begin
                  if (next_id_ff == CAPACITY_CNT) begin
                     rsp_status_in = STATUS_NO_IDS;
                  end else begin
                     val_we        = 1'b1;
                     pri_we        = 1'b1;
                     live_we       = 1'b1;
                     rsp_new_id_in = next_id_ff[ID_W-1:0];
                     next_id_in    = next_id_ff + CNT_W'(1);
                  end
               end
               OP_PROMOTE: begin
                  pri_waddr = id_ff;
                  pri_wdata = pri_rd_ff + PRI_W'(1);
                  if (!id_live) begin
                     rsp_status_in = STATUS_BAD_ID;
                  end else if (pri_rd_ff != PRI_MAX) begin
                     pri_we = 1'b1;
                  end
               end
               OP_IS_VALID: begin
                  rsp_live_in = id_live;
               end
               OP_GET: begin
                  if (!id_live) begin
                     rsp_status_in = STATUS_BAD_ID;
                  end else begin
                     rsp_value_in = val_rd_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            rd_addr = scan_addr_ff[ID_W-1:0];
            if (scan_issue) begin
               scan_addr_in = scan_addr_ff + CNT_W'(1);
               scan_tag_in  = scan_addr_ff[ID_W-1:0];
               pend_in      = 1'b1;
            end
            // later ids win ties
            if (pend_ff && live_rd_ff && (!found_ff || pri_rd_ff >= best_pri_ff)) begin
               found_in    = 1'b1;
               best_pri_in = pri_rd_ff;
               best_id_in  = scan_tag_ff;
            end
            if (scan_done && !found_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_EMPTY;
               rsp_new_id_in = '0;
               rsp_value_in  = '0;
               rsp_pri_in    = '0;
               rsp_live_in   = 1'b0;
            end
         end
         ST_FETCH: begin
            rd_addr = best_id_ff;
         end
         ST_FINISH: begin
            rd_addr       = best_id_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_new_id_in = '0;
            rsp_value_in  = val_rd_ff;
            rsp_pri_in    = best_pri_ff;
            rsp_live_in   = 1'b0;
            live_waddr    = best_id_ff;
            live_wdata    = 1'b0;
            live_we       = (op_ff == OP_POP_MAX);
         end
         default: begin
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_new_id       = rsp_new_id_ff;
   assign rsp_value_out    = rsp_value_ff;
   assign rsp_priority_out = rsp_pri_ff;
   assign rsp_is_live      = rsp_live_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top
   import ipt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam int STALL_LIMIT  = 6000;
   localparam int RANDOM_ITEMS = 515;
   localparam int TAIL_ITEMS   = 40;
   localparam int SCRIPT_ROWS  = 25;

   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      new_id;
      logic [VALUE_W-1:0]   value;
      logic [PRI_W-1:0]     pri;
      logic                 live;
   } answer_type;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [ID_W-1:0]    id;
      logic [VALUE_W-1:0] value;
      bit                 typed;
      answer_type         want;
   } script_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_op;
   logic [ID_W-1:0]     req_entry_id;
   logic [VALUE_W-1:0]  req_value_in;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_new_id;
   logic [VALUE_W-1:0]  rsp_value_out;
   logic [PRI_W-1:0]    rsp_priority_out;
   logic                rsp_is_live;

   // shadow copy of the table
   logic [VALUE_W-1:0] shadow_value [ID_CAPACITY];
   logic [PRI_W-1:0]   shadow_pri   [ID_CAPACITY];
   bit                 shadow_live  [ID_CAPACITY];
   int                 ids_issued;

   answer_type     pending_answers [$];
   script_row_type script [SCRIPT_ROWS];
   int             mismatch_count;
   int             idle_cycles;

   indexed_priority_table_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_entry_id     (req_entry_id),
      .req_value_in     (req_value_in),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_new_id       (rsp_new_id),
      .rsp_value_out    (rsp_value_out),
      .rsp_priority_out (rsp_priority_out),
      .rsp_is_live      (rsp_is_live)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // applies one request to the shadow table and returns what the block should answer
   function automatic answer_type table_answer(input logic [OP_W-1:0] op,
                                               input logic [ID_W-1:0] id,
                                               input logic [VALUE_W-1:0] val);
      answer_type a;
      int         best;
      bit         found;
      a     = '0;
      best  = 0;
      found = 1'b0;
      case (op)
         OP_ADD: begin
            if (ids_issued >= ID_CAPACITY) begin
               a.status = STATUS_NO_IDS;
            end else begin
               shadow_value[ids_issued] = val;
               shadow_pri[ids_issued]   = '0;
               shadow_live[ids_issued]  = 1'b1;
               a.new_id = ID_W'(ids_issued);
               ids_issued++;
            end
         end
         OP_PROMOTE: begin
            if (!shadow_live[id]) begin
               a.status = STATUS_BAD_ID;
            end else if (shadow_pri[id] != PRI_MAX) begin
               shadow_pri[id] = shadow_pri[id] + PRI_W'(1);
            end
         end
         OP_GET_MAX, OP_POP_MAX: begin
            // later ids win ties
            for (int i = 0; i < ID_CAPACITY; i++) begin
               if (shadow_live[i] && (!found || shadow_pri[i] >= shadow_pri[best])) begin
                  found = 1'b1;
                  best  = i;
               end
            end
            if (!found) begin
               a.status = STATUS_EMPTY;
            end else begin
               a.value = shadow_value[best];
               a.pri   = shadow_pri[best];
               if (op == OP_POP_MAX) shadow_live[best] = 1'b0;
            end
         end
         OP_IS_VALID: a.live = shadow_live[id];
         OP_GET: begin
            if (!shadow_live[id]) a.status = STATUS_BAD_ID;
            else a.value = shadow_value[id];
         end
         default: ;
      endcase
      return a;
   endfunction

   // one transaction: optional gap, then raise start and wait until the block is no longer busy
   task automatic issue(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                        input logic [VALUE_W-1:0] val, input int max_gap,
                        input bit typed, input answer_type want);
      int         gap;
      answer_type predicted;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_entry_id <= id;
      req_value_in <= val;
      do @(posedge clock); while (busy);
      predicted = table_answer(op, id, val);
      pending_answers.push_back(typed ? want : predicted);
   endtask

   task automatic draw_request(output logic [OP_W-1:0] op, output logic [ID_W-1:0] id,
                               output logic [VALUE_W-1:0] val);
      int pick;
      int id_pick;
      pick    = $urandom_range(0, 99);
      id_pick = $urandom_range(0, 99);
      if (pick < 25) op = OP_ADD;
      else if (pick < 55) op = OP_PROMOTE;
      else if (pick < 65) op = OP_GET_MAX;
      else if (pick < 73) op = OP_POP_MAX;
      else if (pick < 83) op = OP_IS_VALID;
      else if (pick < 95) op = OP_GET;
      else op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
      // mostly ids already handed out, recent ones favored, some noise
      if (ids_issued == 0 || id_pick >= 85)
         id = ID_W'($urandom_range(0, ID_CAPACITY - 1));
      else if (id_pick < 50)
         id = ID_W'($urandom_range(ids_issued - 1, (ids_issued > 40) ? ids_issued - 40 : 0));
      else
         id = ID_W'($urandom_range(0, ids_issued - 1));
      val = $urandom;
   endtask

   always @(posedge clock) begin : response_check
      answer_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: status %0d new_id %0d value %h priority %0d live %0b",
                           rsp_status, rsp_new_id, rsp_value_out, rsp_priority_out,
                           rsp_is_live);
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_status !== want.status || rsp_new_id !== want.new_id ||
                   rsp_value_out !== want.value || rsp_priority_out !== want.pri ||
                   rsp_is_live !== want.live) begin
                  if (mismatch_count < 10) begin
                     $display("mismatch at %0t: expected status %0d new_id %0d value %h",
                              $realtime, want.status, want.new_id, want.value);
                     $display("  priority %0d live %0b; got status %0d new_id %0d value %h",
                              want.pri, want.live, rsp_status, rsp_new_id, rsp_value_out);
                     $display("  priority %0d live %0b", rsp_priority_out, rsp_is_live);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("indexed_priority_table_unit regression: fail");
      $finish;
   end

   initial begin
      logic [OP_W-1:0]    op;
      logic [ID_W-1:0]    id;
      logic [VALUE_W-1:0] val;
      mismatch_count = 0;
      idle_cycles    = 0;
      ids_issued     = 0;
      foreach (shadow_live[i]) shadow_live[i] = 1'b0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_op       <= '0;
      req_entry_id <= '0;
      req_value_in <= '0;

      script = '{
         '{OP_GET_MAX,   10'd0,    32'd0,          1'b1, '{STATUS_EMPTY,  10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_POP_MAX,   10'd0,    32'd0,          1'b1, '{STATUS_EMPTY,  10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_IS_VALID,  10'd0,    32'd0,          1'b1, '{STATUS_OK,     10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_GET,       10'd1023, 32'd0,          1'b1, '{STATUS_BAD_ID, 10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_PROMOTE,   10'd0,    32'd0,          1'b1, '{STATUS_BAD_ID, 10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_UNUSED_LO, 10'd1023, 32'hFFFF_FFFF,  1'b1, '{STATUS_OK,     10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_UNUSED_HI, 10'd0,    32'd0,          1'b1, '{STATUS_OK,     10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_ADD,       10'd0,    32'd0,          1'b1, '{STATUS_OK,     10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_ADD,       10'd1023, 32'hFFFF_FFFF,  1'b1, '{STATUS_OK,     10'd1, 32'd0, 16'd0, 1'b0}},
         '{OP_ADD,       10'd0,    32'hA5A5_5A5A,  1'b0, '0},
         '{OP_IS_VALID,  10'd1,    32'd0,          1'b1, '{STATUS_OK,     10'd0, 32'd0, 16'd0, 1'b1}},
         '{OP_GET,       10'd1,    32'd0,          1'b1,
           '{STATUS_OK, 10'd0, 32'hFFFF_FFFF, 16'd0, 1'b0}},
         // all at priority zero: the largest id wins
         '{OP_GET_MAX,   10'd0,    32'd0,          1'b0, '0},
         '{OP_PROMOTE,   10'd0,    32'd0,          1'b0, '0},
         '{OP_PROMOTE,   10'd0,    32'd0,          1'b0, '0},
         '{OP_PROMOTE,   10'd1,    32'd0,          1'b0, '0},
         '{OP_GET_MAX,   10'd0,    32'd0,          1'b0, '0},
         '{OP_POP_MAX,   10'd0,    32'd0,          1'b0, '0},
         '{OP_GET,       10'd0,    32'd0,          1'b1, '{STATUS_BAD_ID, 10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_IS_VALID,  10'd0,    32'd0,          1'b1, '{STATUS_OK,     10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_PROMOTE,   10'd0,    32'd0,          1'b1, '{STATUS_BAD_ID, 10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_POP_MAX,   10'd0,    32'd0,          1'b0, '0},
         '{OP_POP_MAX,   10'd0,    32'd0,          1'b0, '0},
         '{OP_POP_MAX,   10'd0,    32'd0,          1'b1, '{STATUS_EMPTY,  10'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_GET,       10'd2,    32'd0,          1'b1, '{STATUS_BAD_ID, 10'd0, 32'd0, 16'd0, 1'b0}}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         issue(script[i].op, script[i].id, script[i].value, 5, script[i].typed, script[i].want);

      repeat (RANDOM_ITEMS) begin
         draw_request(op, id, val);
         issue(op, id, val, 5, 1'b0, '0);
      end

      repeat (TAIL_ITEMS) begin
         draw_request(op, id, val);
         issue(op, id, val, 5, 1'b0, '0);
      end
      start <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("indexed_priority_table_unit regression: pass");
      else
         $display("indexed_priority_table_unit regression: fail");
      $finish;
   end

endmodule
